@@ sv/prime_factorizer_top_assert.svh @@
// ----------------------------------------------------------------------------
// prime factorizer assertion macros
// shared property forms for the factorizer modules, clocked on clk and
// disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef PRIME_FACTORIZER_TOP_ASSERT_SVH
`define PRIME_FACTORIZER_TOP_ASSERT_SVH

// same-cycle implication
`define PF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/pf_pkg.sv @@
// ----------------------------------------------------------------------------
// pf_pkg
// types and constants shared by the prime factorizer modules
// ----------------------------------------------------------------------------
package pf_pkg;

	localparam int FactorWidth = 31;
	localparam int StatusWidth = 2;
	localparam int MaxResults  = 31;
	localparam int CountWidth  = 5;

	localparam logic [StatusWidth-1:0] ST_OK      = 2'd0;
	localparam logic [StatusWidth-1:0] ST_ONE     = 2'd1;
	localparam logic [StatusWidth-1:0] ST_NOT_POS = 2'd2;

	// divider status toward the controller
	typedef struct packed {
		logic done;
		logic rem_zero;
	} pf_div_res_t;

endpackage

@@ sv/pf_divider.sv @@
// ----------------------------------------------------------------------------
// pf_divider
// bit-serial restoring divider: one quotient bit per cycle, the dividend
// register shifts out at the top while quotient bits shift in at the bottom
// ----------------------------------------------------------------------------
module pf_divider import pf_pkg::*; #(
	parameter int VW = 31,
	parameter int DW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [VW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic [VW-1:0] quotient,
	output pf_div_res_t   res
);

	localparam int CW = $clog2(VW + 1);

	logic [VW-1:0] dq_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] dv_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign trial = {r_q, dq_q[VW-1]};
	assign diff  = trial - {1'b0, dv_q};
	assign ge    = trial >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CW'(VW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dq_q <= dividend;
			r_q  <= '0;
			dv_q <= divisor;
		end else if (cnt_q != '0) begin
			dq_q <= {dq_q[VW-2:0], ge};
			// partial remainder stays below the divisor
			r_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign quotient     = dq_q;
	assign res.done     = done_q;
	assign res.rem_zero = (r_q == '0);

	`include "prime_factorizer_top_assert.svh"

	`PF_ASSERT_NEXT(a_done_ends_run, (cnt_q == CW'(1)) && !go, done_q, "divider missed done")
	`PF_ASSERT_NOW(a_done_idle, done_q, cnt_q == '0, "divider done while running")

endmodule

@@ sv/prime_factorizer_top.sv @@
// ----------------------------------------------------------------------------
// prime_factorizer_top
// trial-division prime factorization, factors emitted in ascending order
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     start & !busy          number
//  result    valid (one cycle)      factor, status, last
//
//  one trial division is a bit-serial divide, launched in S_GO and awaited in
//  S_WAIT, so an input runs one such divide per trial divisor plus one per factor found;
//  worst case about 46341 trial divisors at DATA_WIDTH 32
//  zero, negative and one inputs answer in the cycle after start without going busy
//  reset clears control and the result strobe; the receiver cannot stall
// ----------------------------------------------------------------------------
module prime_factorizer_top import pf_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [31:0]     number,
	output logic                   busy,
	output logic                   valid,
	output logic [FactorWidth-1:0] factor,
	output logic [StatusWidth-1:0] status,
	output logic                   last
);

	localparam int VW = DATA_WIDTH - 1;
	localparam int DW = DATA_WIDTH / 2 + 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_GO   = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;

	logic [1:0]             state_q;
	logic [VW-1:0]          rem_q;
	logic [DW-1:0]          d_q;
	logic [CountWidth-1:0]  n_q;
	logic                   valid_q;
	logic [FactorWidth-1:0] factor_q;
	logic [StatusWidth-1:0] status_q;
	logic                   last_q;

	logic [63:0]            num_ext;
	logic [DATA_WIDTH-1:0]  v;
	logic [VW-1:0]          quot;
	pf_div_res_t            div_res;
	logic                   div_go;
	logic                   cap;

	assign num_ext = {{32{number[31]}}, number};
	assign v       = num_ext[DATA_WIDTH-1:0];
	assign div_go  = (state_q == S_GO);
	assign cap     = (n_q == CountWidth'(MaxResults - 1));

	pf_divider #(
		.VW(VW),
		.DW(DW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div_go),
		.dividend(rem_q),
		.divisor (d_q),
		.quotient(quot),
		.res     (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
			n_q     <= '0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (v[DATA_WIDTH-1] || v == '0 || v == DATA_WIDTH'(1)) begin
							valid_q <= 1'b1;
						end else begin
							n_q     <= '0;
							state_q <= S_GO;
						end
					end
				end
				S_GO: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_res.done) begin
						if (div_res.rem_zero) begin
							valid_q <= 1'b1;
							n_q     <= n_q + CountWidth'(1);
							state_q <= (quot == VW'(1) || cap) ? S_IDLE : S_GO;
						end else if (VW'(d_q) > quot) begin
							valid_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_GO;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				d_q      <= DW'(2);
				rem_q    <= v[VW-1:0];
				factor_q <= '0;
				last_q   <= 1'b1;
				status_q <= (v == DATA_WIDTH'(1)) ? ST_ONE : ST_NOT_POS;
			end
			S_WAIT: begin
				if (div_res.done) begin
					status_q <= ST_OK;
					if (div_res.rem_zero) begin
						factor_q <= FactorWidth'(d_q);
						last_q   <= (quot == VW'(1)) || cap;
						rem_q    <= quot;
					end else if (VW'(d_q) > quot) begin
						// cofactor left over is prime
						factor_q <= FactorWidth'(rem_q);
						last_q   <= 1'b1;
					end else begin
						d_q <= d_q + DW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign valid  = valid_q;
	assign factor = factor_q;
	assign status = status_q;
	assign last   = last_q;

	`include "prime_factorizer_top_assert.svh"

	`PF_ASSERT_NEXT(a_accept_acts, start && !busy, busy || valid, "accepted beat dropped")
	`PF_ASSERT_NOW(a_err_is_last, valid && status != ST_OK, last && factor == '0,
		"error result not last")
	`PF_ASSERT_NOW(a_done_in_wait, div_res.done, state_q == S_WAIT, "divider done out of turn")
	`PF_ASSERT_NOW(a_factor_nonzero, valid && status == ST_OK, factor != '0, "zero factor")

endmodule

@@ tb/sv/prime_factorizer_top_tb.sv @@
// ----------------------------------------------------------------------------
// prime_factorizer_top_tb
// drives numbers into the factorizer, predicts the ascending prime factors of
// each one by trial division and checks every result beat against them; a
// directed table comes first, then random numbers, most built from small primes
// ----------------------------------------------------------------------------
module prime_factorizer_top_tb;
	import pf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NumRandom = 78;
	localparam int NumDirected = 22;

	typedef struct packed {
		logic [FactorWidth-1:0] factor;
		logic [StatusWidth-1:0] status;
		logic                   last;
	} factor_beat_t;

	typedef struct packed {
		logic [31:0]  num;
		logic         typed;
		factor_beat_t beat;
	} stim_row_t;

	// typed rows carry their single expected beat, the rest go to the predictor
	localparam stim_row_t DirectedRows [NumDirected] = '{
		'{32'h8000_0000, 1'b1, '{31'd0, ST_NOT_POS, 1'b1}},
		'{32'hFFFF_FFFF, 1'b1, '{31'd0, ST_NOT_POS, 1'b1}},
		'{32'd0,         1'b1, '{31'd0, ST_NOT_POS, 1'b1}},
		'{32'd1,         1'b1, '{31'd0, ST_ONE, 1'b1}},
		'{32'd2,         1'b1, '{31'd2, ST_OK, 1'b1}},
		'{32'd3,         1'b1, '{31'd3, ST_OK, 1'b1}},
		'{32'd4,         1'b0, '0},
		'{32'd6,         1'b0, '0},
		'{32'd9,         1'b0, '0},
		'{32'd49,        1'b0, '0},
		'{32'd360360,    1'b0, '0},
		'{32'd65521,     1'b0, '0},
		'{32'd994009,    1'b0, '0},
		'{32'd1000003,   1'b0, '0},
		'{32'h4000_0000, 1'b0, '0},
		'{32'h7FFF_FFFE, 1'b0, '0},
		'{32'h5555_5555, 1'b0, '0},
		'{32'h2AAA_AAAA, 1'b0, '0},
		'{32'h4000_0001, 1'b0, '0},
		'{32'hAAAA_AAAA, 1'b1, '{31'd0, ST_NOT_POS, 1'b1}},
		'{32'hFFFF_CFC7, 1'b1, '{31'd0, ST_NOT_POS, 1'b1}},
		'{32'd30030,     1'b0, '0}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic signed [31:0]     number;
	logic                   busy;
	logic                   valid;
	logic [FactorWidth-1:0] factor;
	logic [StatusWidth-1:0] status;
	logic                   last;

	factor_beat_t pending_factors[$];
	int           mismatch_count = 0;
	int           no_idle_left = 0;

	prime_factorizer_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.number (number),
		.busy   (busy),
		.valid  (valid),
		.factor (factor),
		.status (status),
		.last   (last)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#300_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// trial division, ascending factors, last one marked
	function automatic void predict_factors(input logic signed [31:0] n);
		longint unsigned rest;
		longint unsigned divisor;
		factor_beat_t    beat;
		int              count;
		bit              done;
		bit              found;
		count = 0;
		done = 1'b0;
		if (n <= 0) begin
			pending_factors.push_back('{'0, ST_NOT_POS, 1'b1});
			return;
		end
		if (n == 1) begin
			pending_factors.push_back('{'0, ST_ONE, 1'b1});
			return;
		end
		rest = longint'(n);
		divisor = 2;
		while (!done) begin
			found = 1'b1;
			if (rest % divisor == 0) begin
				beat.factor = divisor[FactorWidth-1:0];
				rest = rest / divisor;
				done = (rest == 1);
			end else if (divisor > rest / divisor) begin
				// nothing up to the square root divides: the rest is prime
				beat.factor = rest[FactorWidth-1:0];
				rest = 1;
				done = 1'b1;
			end else begin
				divisor++;
				found = 1'b0;
			end
			if (found) begin
				if (count == MaxResults - 1)
					done = 1'b1;
				beat.status = ST_OK;
				beat.last = done;
				pending_factors.push_back(beat);
				count++;
			end
		end
	endfunction

	// product of random factors no larger than max_prime, kept below 2^31
	function automatic logic signed [31:0] draw_product(input int max_prime);
		longint unsigned acc;
		longint unsigned pick;
		int              terms;
		acc = 1;
		terms = $urandom_range(1, 12);
		for (int i = 0; i < terms; i++) begin
			pick = $urandom_range(2, max_prime);
			if (acc * pick > 64'h7FFF_FFFF)
				break;
			acc = acc * pick;
		end
		return acc[31:0];
	endfunction

	function automatic int draw_gap();
		if (no_idle_left > 0) begin
			no_idle_left--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0)
			no_idle_left = $urandom_range(4, 12);
		return $urandom_range(0, 9);
	endfunction

	// one input beat: returns right after the accepting edge
	task automatic send_number(input logic signed [31:0] n, input logic typed,
			input factor_beat_t typed_beat);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		number <= n;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (typed)
			pending_factors.push_back(typed_beat);
		else
			predict_factors(n);
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_factors.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin : check_beats
		factor_beat_t want;
		if (arst_n && valid) begin
			if (pending_factors.size() == 0) begin
				report_mismatch($sformatf("unexpected beat factor %0d status %0d last %0d",
					factor, status, last));
			end else begin
				want = pending_factors.pop_front();
				if (factor !== want.factor)
					report_mismatch($sformatf("factor %0d, expected %0d", factor, want.factor));
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
				if (last !== want.last)
					report_mismatch($sformatf("last %0d, expected %0d", last, want.last));
			end
		end
	end

	initial begin : stimulus
		logic signed [31:0] n;
		int                 pick;
		arst_n = 1'b0;
		start = 1'b0;
		number = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DirectedRows[i])
			send_number(DirectedRows[i].num, DirectedRows[i].typed, DirectedRows[i].beat);

		// hold off until the directed part has fully drained
		drain_results();

		for (int i = 0; i < NumRandom; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 15)
				n = $urandom | 32'h8000_0000;
			else if (pick < 19)
				n = $urandom_range(0, 1);
			else if (pick < 27)
				n = draw_product(1500);
			else
				n = draw_product(97);
			send_number(n, 1'b0, '0);
			if (i % 25 == 24)
				drain_results();
		end

		drain_results();
		repeat (100) @(negedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
